// ===== hdl/dwpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual wheel PI speed control package
// Shared widths, register indexes, sequencer codes and control structs.
// ----------------------------------------------------------------------------
package dwpi_pkg;

   localparam int WHEEL_COUNT = 2;
   localparam int WHEEL_IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

   // field widths
   localparam int CMD_W      = 1;
   localparam int WHEEL_W    = 1;
   localparam int TGT_W      = 14;
   localparam int ERPM_W     = 18;
   localparam int DT_W       = 16;
   localparam int CUR_W      = 17;
   localparam int KP_W       = 24;
   localparam int KI_W       = 24;
   localparam int CLIM_W     = 16;
   localparam int ILIM_W     = 40;
   localparam int SCALE_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   // shared multiplier and arithmetic widths
   localparam int MUL_A_W    = 24;
   localparam int MUL_B_W    = 20;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ERR_W      = 35;
   localparam int ERR_MAG_W  = 34;
   localparam int INT_W      = ILIM_W + 1;
   localparam int INT_MAG_W  = ILIM_W;
   localparam int ACC_W      = 64;
   localparam int DTP_W      = ERR_MAG_W + DT_W;
   localparam int STEP_MAG_W = DTP_W + 1 - 16;
   localparam int SUM_W      = INT_W + 1;
   localparam int CAP_SHIFT  = 52;
   localparam int CAP_W      = CAP_SHIFT + 1;
   localparam int P_W        = CAP_W + 1;
   localparam int TOT_W      = P_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PROPORTIONAL_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_LIMIT_MA  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ERPM_SCALE        = 3'd4;

   // item commands
   localparam logic [CMD_W-1:0] CMD_STEP  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SPEED,
      MUL_DT_LO,
      MUL_DT_HI,
      MUL_KP_LO,
      MUL_KP_HI,
      MUL_KI_LO,
      MUL_KI_HI
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD_HI
   } acc_op_type;

   typedef struct packed {
      logic        in_load;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        err_load;
      logic        integ_upd;
      logic        integ_clr;
      logic        p_load;
      logic        out_load;
      logic        out_zero;
   } dwpi_cmd_type;

   typedef struct packed {
      logic [KP_W-1:0]    proportional_gain;
      logic [KI_W-1:0]    integral_gain;
      logic [CLIM_W-1:0]  current_limit_ma;
      logic [ILIM_W-1:0]  integral_limit;
      logic [SCALE_W-1:0] erpm_scale;
   } dwpi_cfg_type;

endpackage

// ===== hdl/dwpi_if.sv =====
// ----------------------------------------------------------------------------
// Dual wheel PI speed control channels
// Valid/ready interfaces for the request, response and register write beats.
// ----------------------------------------------------------------------------
interface dwpi_req_if;
   import dwpi_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [WHEEL_W-1:0]       wheel;
   logic signed [TGT_W-1:0]  target_speed;
   logic signed [ERPM_W-1:0] measured_erpm;
   logic [DT_W-1:0]          time_step;

   modport source (output valid, command, wheel, target_speed, measured_erpm, time_step,
                   input ready);
   modport sink (input valid, command, wheel, target_speed, measured_erpm, time_step,
                 output ready);
endinterface

interface dwpi_rsp_if;
   import dwpi_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [WHEEL_W-1:0]      wheel_out;
   logic signed [CUR_W-1:0] current_ma;

   modport source (output valid, wheel_out, current_ma, input ready);
   modport sink (input valid, wheel_out, current_ma, output ready);
endinterface

interface dwpi_csr_if;
   import dwpi_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/dwpi_csr.sv =====
// ----------------------------------------------------------------------------
// Dual wheel PI speed control registers
// Gain, limit and scale registers, written one beat at a time.
// ----------------------------------------------------------------------------
module dwpi_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [dwpi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dwpi_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            csr_ready,
   output dwpi_pkg::dwpi_cfg_type          cfg
);
   import dwpi_pkg::*;

   dwpi_cfg_type cfg_ff;
   dwpi_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PROPORTIONAL_GAIN: cfg_in.proportional_gain = csr_data[KP_W-1:0];
            REG_INTEGRAL_GAIN:     cfg_in.integral_gain     = csr_data[KI_W-1:0];
            REG_CURRENT_LIMIT_MA:  cfg_in.current_limit_ma  = csr_data[CLIM_W-1:0];
            REG_INTEGRAL_LIMIT:    cfg_in.integral_limit    = csr_data[ILIM_W-1:0];
            REG_ERPM_SCALE:        cfg_in.erpm_scale        = csr_data[SCALE_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/dwpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dual wheel PI speed control sequencer
// Steps the shared multiplier and accumulator through one control update.
// ----------------------------------------------------------------------------
module dwpi_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [dwpi_pkg::CMD_W-1:0]   req_command,
   output logic                         req_ready,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output dwpi_pkg::dwpi_cmd_type       cmd
);
   import dwpi_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_MUL_SPEED = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ERROR     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DT_LO     = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DT_HI     = 4'd3;
   localparam logic [STEP_W-1:0] STEP_KP_LO     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_KP_HI     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_KI_LO     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_KI_HI     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_KI_SUM    = 4'd8;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = MUL_NONE;
      cmd.acc_op    = ACC_HOLD;
      cmd.in_load   = req_valid && (state_ff == ST_IDLE);
      case (state_ff)
         ST_RUN: begin
            case (step_ff)
               STEP_MUL_SPEED: cmd.mul_sel = MUL_SPEED;
               STEP_ERROR:     cmd.err_load = 1'b1;
               STEP_DT_LO:     cmd.mul_sel = MUL_DT_LO;
               STEP_DT_HI: begin
                  cmd.mul_sel = MUL_DT_HI;
                  cmd.acc_op  = ACC_LOAD;
               end
               STEP_KP_LO: begin
                  cmd.mul_sel = MUL_KP_LO;
                  cmd.acc_op  = ACC_ADD_HI;
               end
               STEP_KP_HI: begin
                  cmd.mul_sel   = MUL_KP_HI;
                  cmd.integ_upd = 1'b1;
                  cmd.acc_op    = ACC_LOAD;
               end
               STEP_KI_LO: begin
                  cmd.mul_sel = MUL_KI_LO;
                  cmd.acc_op  = ACC_ADD_HI;
               end
               STEP_KI_HI: begin
                  cmd.mul_sel = MUL_KI_HI;
                  cmd.p_load  = 1'b1;
                  cmd.acc_op  = ACC_LOAD;
               end
               STEP_KI_SUM:    cmd.acc_op = ACC_ADD_HI;
               default:        cmd.acc_op = ACC_HOLD;
            endcase
         end
         ST_CLEAR: begin
            cmd.integ_clr = slot_free;
            cmd.out_zero  = 1'b1;
            cmd.out_load  = slot_free;
         end
         ST_FINISH: cmd.out_load = slot_free;
         default:   cmd.in_load  = req_valid && (state_ff == ST_IDLE);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.in_load) begin
               state_in = (req_command == CMD_CLEAR) ? ST_CLEAR : ST_RUN;
               step_in  = STEP_MUL_SPEED;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_KI_SUM) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_CLEAR, ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // hold the response beat until taken
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_clear_goes_clear : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_command == CMD_CLEAR)) |=> (state_ff == ST_CLEAR))
      else $error("clear beat did not enter clear state");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while held");

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

   a_run_no_accept : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !cmd.in_load && !cmd.out_load)
      else $error("accept or response during update sequence");

endmodule

// ===== hdl/dwpi_dp.sv =====
// ----------------------------------------------------------------------------
// Dual wheel PI speed control datapath
// Shared 24x20 multiplier, product accumulator, integrators and output clamp.
// ----------------------------------------------------------------------------
module dwpi_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  dwpi_pkg::dwpi_cmd_type              cmd,
   input  dwpi_pkg::dwpi_cfg_type              cfg,
   input  logic [dwpi_pkg::WHEEL_W-1:0]        req_wheel,
   input  logic signed [dwpi_pkg::TGT_W-1:0]   req_target_speed,
   input  logic signed [dwpi_pkg::ERPM_W-1:0]  req_measured_erpm,
   input  logic [dwpi_pkg::DT_W-1:0]           req_time_step,
   output logic [dwpi_pkg::WHEEL_W-1:0]        rsp_wheel_out,
   output logic signed [dwpi_pkg::CUR_W-1:0]   rsp_current_ma
);
   import dwpi_pkg::*;

   localparam logic [ACC_W-1:0] MAG_CAP = ACC_W'(1) << CAP_SHIFT;

   function automatic logic [CAP_W-1:0] cap_mag(input logic [ACC_W-1:0] v);
      return (v > MAG_CAP) ? MAG_CAP[CAP_W-1:0] : v[CAP_W-1:0];
   endfunction

   // latched item
   logic [WHEEL_W-1:0]      wheel_ff;
   logic [WHEEL_IDX_W-1:0]  idx_ff, idx_in;
   logic signed [TGT_W-1:0] target_ff;
   logic [ERPM_W-1:0]       erpm_mag_ff;
   logic                    erpm_neg_ff;
   logic [DT_W-1:0]         dt_ff;

   // multiplier and accumulator
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   // error
   logic signed [ERR_W-1:0] target_q16, speed_ext, err_in;
   logic [ERR_MAG_W-1:0]    err_mag_ff;
   logic                    err_neg_ff;

   // integrators
   logic signed [INT_W-1:0] integ_ff [WHEEL_COUNT];
   logic [DTP_W:0]          dtp_round;
   logic [STEP_MAG_W-1:0]   step_mag;
   logic signed [SUM_W-1:0] step_s, sum_s, lim_pos, lim_neg, clamp_s;
   logic signed [INT_W-1:0] integ_new;
   logic [INT_MAG_W-1:0]    integ_mag_ff;
   logic                    integ_neg_ff;

   // output
   logic signed [P_W-1:0]   p_ff, p_in, i_s;
   logic signed [TOT_W-1:0] total_s, olim_s, tot_mag;
   logic signed [CUR_W-1:0] cur_in;
   logic [WHEEL_W-1:0]      rsp_wheel_ff;
   logic signed [CUR_W-1:0] rsp_current_ff;

   assign rsp_wheel_out  = rsp_wheel_ff;
   assign rsp_current_ma = rsp_current_ff;

   // out-of-range wheel maps to the last channel
   always_comb begin
      if (int'(req_wheel) >= WHEEL_COUNT) begin
         idx_in = WHEEL_IDX_W'(WHEEL_COUNT - 1);
      end else begin
         idx_in = WHEEL_IDX_W'(req_wheel);
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         MUL_SPEED: begin
            mul_a = MUL_A_W'(cfg.erpm_scale);
            mul_b = MUL_B_W'(erpm_mag_ff);
         end
         MUL_DT_LO: begin
            mul_a = MUL_A_W'(dt_ff);
            mul_b = err_mag_ff[MUL_B_W-1:0];
         end
         MUL_DT_HI: begin
            mul_a = MUL_A_W'(dt_ff);
            mul_b = MUL_B_W'(err_mag_ff[ERR_MAG_W-1:MUL_B_W]);
         end
         MUL_KP_LO: begin
            mul_a = MUL_A_W'(cfg.proportional_gain);
            mul_b = err_mag_ff[MUL_B_W-1:0];
         end
         MUL_KP_HI: begin
            mul_a = MUL_A_W'(cfg.proportional_gain);
            mul_b = MUL_B_W'(err_mag_ff[ERR_MAG_W-1:MUL_B_W]);
         end
         MUL_KI_LO: begin
            mul_a = MUL_A_W'(cfg.integral_gain);
            mul_b = integ_mag_ff[MUL_B_W-1:0];
         end
         MUL_KI_HI: begin
            mul_a = MUL_A_W'(cfg.integral_gain);
            mul_b = MUL_B_W'(integ_mag_ff[INT_MAG_W-1:MUL_B_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD:   acc_in = ACC_W'(prod_ff);
         ACC_ADD_HI: acc_in = acc_ff + (ACC_W'(prod_ff) << MUL_B_W);
         default:    acc_in = acc_ff;
      endcase
   end

   // speed error in Q16 mm/s from the speed product
   always_comb begin
      target_q16 = {{(ERR_W - TGT_W - 16){target_ff[TGT_W-1]}}, target_ff, 16'h0000};
      speed_ext  = ERR_W'(prod_ff[ERR_MAG_W-1:0]);
      err_in     = erpm_neg_ff ? (target_q16 + speed_ext) : (target_q16 - speed_ext);
   end

   // integrator step: floor of error * dt / 2^16, then clamp
   always_comb begin
      dtp_round = err_neg_ff ? ({1'b0, acc_ff[DTP_W-1:0]} + (DTP_W + 1)'(16'hFFFF))
                             : {1'b0, acc_ff[DTP_W-1:0]};
      step_mag  = dtp_round[DTP_W:16];
      step_s    = err_neg_ff ? -SUM_W'(step_mag) : SUM_W'(step_mag);
      sum_s     = SUM_W'(integ_ff[idx_ff]) + step_s;
      lim_pos   = SUM_W'(cfg.integral_limit);
      lim_neg   = -lim_pos;
      if (sum_s > lim_pos) begin
         clamp_s = lim_pos;
      end else if (sum_s < lim_neg) begin
         clamp_s = lim_neg;
      end else begin
         clamp_s = sum_s;
      end
      integ_new = INT_W'(clamp_s);
   end

   // proportional plus integral, saturate, truncate toward zero
   always_comb begin
      p_in    = err_neg_ff ? -P_W'(cap_mag(acc_ff)) : P_W'(cap_mag(acc_ff));
      i_s     = integ_neg_ff ? -P_W'(cap_mag(acc_ff)) : P_W'(cap_mag(acc_ff));
      total_s = TOT_W'(p_ff) + TOT_W'(i_s);
      olim_s  = TOT_W'({cfg.current_limit_ma, 32'h0000_0000});
      tot_mag = (total_s < 0) ? -total_s : total_s;
      if (cmd.out_zero) begin
         cur_in = '0;
      end else if (total_s > olim_s) begin
         cur_in = CUR_W'(cfg.current_limit_ma);
      end else if (total_s < -olim_s) begin
         cur_in = -CUR_W'(cfg.current_limit_ma);
      end else if (total_s < 0) begin
         cur_in = -CUR_W'(tot_mag >>> 32);
      end else begin
         cur_in = CUR_W'(tot_mag >>> 32);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      if (cmd.in_load) begin
         wheel_ff    <= req_wheel;
         idx_ff      <= idx_in;
         target_ff   <= req_target_speed;
         erpm_neg_ff <= req_measured_erpm[ERPM_W-1];
         erpm_mag_ff <= req_measured_erpm[ERPM_W-1] ? ERPM_W'(-req_measured_erpm)
                                                    : ERPM_W'(req_measured_erpm);
         dt_ff       <= req_time_step;
      end
      if (cmd.err_load) begin
         err_neg_ff <= err_in[ERR_W-1];
         err_mag_ff <= err_in[ERR_W-1] ? ERR_MAG_W'(-err_in) : ERR_MAG_W'(err_in);
      end
      if (cmd.integ_upd) begin
         integ_neg_ff <= integ_new[INT_W-1];
         integ_mag_ff <= integ_new[INT_W-1] ? INT_MAG_W'(-integ_new) : INT_MAG_W'(integ_new);
      end
      if (cmd.p_load) begin
         p_ff <= p_in;
      end
      if (reset) begin
         rsp_wheel_ff   <= '0;
         rsp_current_ff <= '0;
      end else if (cmd.out_load) begin
         rsp_wheel_ff   <= wheel_ff;
         rsp_current_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WHEEL_COUNT; k++) begin
            integ_ff[k] <= '0;
         end
      end else if (cmd.integ_clr) begin
         for (int k = 0; k < WHEEL_COUNT; k++) begin
            integ_ff[k] <= '0;
         end
      end else if (cmd.integ_upd) begin
         integ_ff[idx_ff] <= integ_new;
      end
   end

   a_integ_in_limit : assert property (@(posedge clock) disable iff (reset)
      $past(cmd.integ_upd) |-> (integ_mag_ff <= cfg.integral_limit))
      else $error("integrator outside its clamp");

   a_clear_zeroes : assert property (@(posedge clock) disable iff (reset)
      cmd.integ_clr |=> (integ_ff[0] == '0) && (integ_ff[WHEEL_COUNT-1] == '0))
      else $error("integrators not cleared");

endmodule

// ===== hdl/dual_wheel_pi_speed_control_top.sv =====
// ----------------------------------------------------------------------------
// Dual wheel PI speed control
// A step beat runs the update, using the single 24x20 multiplier seven times
// in sequence; a clear beat zeroes both integrators. A new beat is accepted
// only once the last response is loaded, which waits for a free response slot.
// Reset (synchronous): clears CSRs, response, both integrators and sequencer.
// ----------------------------------------------------------------------------
module dual_wheel_pi_speed_control_top (
   input  logic       clock,
   input  logic       reset,
   dwpi_req_if.sink   req_bus,
   dwpi_rsp_if.source rsp_bus,
   dwpi_csr_if.sink   csr_bus
);
   import dwpi_pkg::*;

   dwpi_cfg_type cfg;
   dwpi_cmd_type cmd;
   logic         csr_ready;
   logic         req_ready;
   logic         rsp_valid;

   assign csr_bus.ready = csr_ready;
   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

   dwpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   dwpi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_ready),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_valid),
      .cmd         (cmd)
   );

   dwpi_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_wheel         (req_bus.wheel),
      .req_target_speed  (req_bus.target_speed),
      .req_measured_erpm (req_bus.measured_erpm),
      .req_time_step     (req_bus.time_step),
      .rsp_wheel_out     (rsp_bus.wheel_out),
      .rsp_current_ma    (rsp_bus.current_ma)
   );

endmodule
